### rtl/egb_pkg.sv
// Shared types and constants for the extended GCD block.
`timescale 1ns / 1ps
`default_nettype none

package egb_pkg;

  localparam int WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL_S,
    ST_MUL_T,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/egb_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module egb_div #(
  parameter int WIDTH = egb_pkg::WIDTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wire  [WIDTH-1:0]        dividend,
  input  wire  [WIDTH-1:0]        divisor,
  output logic [WIDTH-1:0]        quotient,
  output logic [WIDTH-1:0]        remainder,
  output egb_pkg::div_stat_t      stat
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             busy;
  logic             done;

  assign trial = {remainder, quotient[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out of the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (!diff[WIDTH]) begin
        remainder <= diff[WIDTH-1:0];
        quotient  <= {quotient[WIDTH-2:0], 1'b1};
      end else begin
        remainder <= trial[WIDTH-1:0];
        quotient  <= {quotient[WIDTH-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    stat.busy = busy;
    stat.done = done;
  end

endmodule

`default_nettype wire

### rtl/extended_gcd_bezout.sv
// Per Euclid step: a check, the bit-serial division, its done pulse, a multiply for s,
// a multiply for t and an update; plus an accept in idle and a final check per item.
// Throughput: one item at a time, bounded by the bit-serial divider loop.
// The next item is accepted while a finished result still waits on the output.
// Reset: rst synchronous, active high; clears the sequencer, divider and output valid.
`timescale 1ns / 1ps
`default_nettype none

module extended_gcd_bezout #(
  parameter int WIDTH = egb_pkg::WIDTH_DEF,
  localparam int IN_W  = ((2 * WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * WIDTH + 2 + 7) / 8) * 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  wire  [IN_W-1:0]  s_tdata,   // operand_a, operand_b
  output logic             m_tvalid,
  input  wire              m_tready,
  output logic [OUT_W-1:0] m_tdata    // divisor, coeff_a, coeff_b
);

  egb_pkg::state_t    state;
  egb_pkg::state_t    state_next;
  egb_pkg::div_stat_t div_stat;

  logic [WIDTH-1:0] rem_prev;
  logic [WIDTH-1:0] rem_cur;
  logic [WIDTH:0]   sa_prev;
  logic [WIDTH:0]   sa_cur;
  logic [WIDTH:0]   tb_prev;
  logic [WIDTH:0]   tb_cur;
  logic [WIDTH:0]   prod;
  logic [WIDTH-1:0] div_quot;
  logic [WIDTH-1:0] div_rem;

  logic             div_start;
  logic             load_out;
  logic             out_free;
  logic [WIDTH:0]   mul_b;
  logic [2*WIDTH+1:0] mul_full;
  logic [OUT_W-1:0] out_word;

  egb_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rem_prev),
    .divisor   (rem_cur),
    .quotient  (div_quot),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign out_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      egb_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = egb_pkg::ST_CHECK;
      end
      egb_pkg::ST_CHECK: begin
        if (rem_cur != '0) state_next = egb_pkg::ST_DIV;
        else if (out_free) state_next = egb_pkg::ST_IDLE;
      end
      egb_pkg::ST_DIV: begin
        if (div_stat.done) state_next = egb_pkg::ST_MUL_S;
      end
      egb_pkg::ST_MUL_S: state_next = egb_pkg::ST_MUL_T;
      egb_pkg::ST_MUL_T: state_next = egb_pkg::ST_UPD;
      egb_pkg::ST_UPD:   state_next = egb_pkg::ST_CHECK;
      default:           state_next = egb_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready  = (state == egb_pkg::ST_IDLE);
    div_start = (state == egb_pkg::ST_CHECK) && (rem_cur != '0);
    load_out  = (state == egb_pkg::ST_CHECK) && (rem_cur == '0) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= egb_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Shared multiplier: quotient times the current s, then the current t.
  // Products wrap at WIDTH+1 bits, which is exact for the coefficients.
  assign mul_b    = (state == egb_pkg::ST_MUL_S) ? sa_cur : tb_cur;
  assign mul_full = {1'b0, div_quot} * mul_b;

  always_ff @(posedge clk) begin
    case (state)
      egb_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          rem_prev <= s_tdata[WIDTH-1:0];
          rem_cur  <= s_tdata[2*WIDTH-1:WIDTH];
          sa_prev  <= (WIDTH+1)'(1);
          sa_cur   <= '0;
          tb_prev  <= '0;
          tb_cur   <= (WIDTH+1)'(1);
        end
      end
      egb_pkg::ST_MUL_S: begin
        prod <= mul_full[WIDTH:0];
      end
      egb_pkg::ST_MUL_T: begin
        sa_prev <= sa_cur;
        sa_cur  <= sa_prev - prod;
        prod    <= mul_full[WIDTH:0];
      end
      egb_pkg::ST_UPD: begin
        tb_prev  <= tb_cur;
        tb_cur   <= tb_prev - prod;
        rem_prev <= rem_cur;
        rem_cur  <= div_rem;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_word = '0;
    out_word[WIDTH-1:0]           = rem_prev;
    out_word[2*WIDTH:WIDTH]       = sa_prev;
    out_word[3*WIDTH+1:2*WIDTH+1] = tb_prev;
  end

  // Output register: hold until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) m_tdata <= out_word;
  end

`ifndef ASSERT_OFF
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == egb_pkg::ST_IDLE) |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == egb_pkg::ST_DIV))
    else $error("divider finished outside of division wait");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid)
    else $error("result load did not raise output valid");

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire
